// File: hw/rtl/iog_pkg.sv
// ----------------------------------------------------------------------------
// Interval overlap grouping package
// Shared payload types and the sequencer state encoding.
// ----------------------------------------------------------------------------
package iog_pkg;

  // Payload of one input transfer: one interval.
  typedef struct packed {
    logic signed [15:0] end_a;
    logic signed [15:0] end_b;
    logic               last_interval;
  } span_in_t;

  // Payload of one output transfer: the grouping of one interval.
  typedef struct packed {
    logic [5:0] interval_index;
    logic [5:0] component_label;
    logic       side;
    logic       last_result;
    logic       overflow;
  } grouping_t;

  // Sequencer states, one-hot.
  typedef enum logic [8:0] {
    ST_LOAD   = 9'b000000001,
    ST_SCAN   = 9'b000000010,
    ST_POP    = 9'b000000100,
    ST_STKRD  = 9'b000001000,
    ST_NODERD = 9'b000010000,
    ST_CMPRD  = 9'b000100000,
    ST_CMP    = 9'b001000000,
    ST_OUTRD  = 9'b010000000,
    ST_OUT    = 9'b100000000
  } iog_state_t;

endpackage

// File: hw/rtl/iog_stream_if.sv
// ----------------------------------------------------------------------------
// Valid/ready stream interface
// Carries a payload of a given type between a source and a sink.
// ----------------------------------------------------------------------------
interface iog_stream_if #(parameter type payload_t = logic) (input logic clk);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: hw/rtl/iog_mem.sv
// ----------------------------------------------------------------------------
// Interval overlap grouping memory
// Single write port, registered read port.
// ----------------------------------------------------------------------------
module iog_mem #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// File: hw/rtl/interval_overlap_grouping_core.sv
// ----------------------------------------------------------------------------
// Interval overlap grouping core
// Loads intervals, labels overlap components by a depth-first walk and
// spreads the components over two sides.
// ----------------------------------------------------------------------------
// Channel  Dir  Payload
// in_ch    in   end_a, end_b, last_interval
// out_ch   out  interval_index, component_label, side, last_result, overflow
//
// Loading accepts one interval per cycle; input is ready only while loading.
// After the last interval the walk scans the interval indices, pops the
// stack and compares each popped node with every interval; a closing step
// for each component chooses its side. Output reads and presents each
// result, and a final step clears the set. Reset is synchronous and needs
// no clearing pass. A stalled output holds its result.
// ----------------------------------------------------------------------------
module interval_overlap_grouping_core
  import iog_pkg::*;
#(
  parameter int MAX_INTERVALS = 64,
  parameter int ENDPOINT_BITS = 16
) (
  input logic clk,
  input logic rst,
  iog_stream_if.sink   in_ch,
  iog_stream_if.source out_ch
);
  localparam int IW = $clog2(MAX_INTERVALS);
  localparam int CW = IW + 1;
  localparam int EB = ENDPOINT_BITS;

  iog_state_t state;
  logic [CW-1:0] count;
  logic          ovf;
  logic [CW-1:0] scan_i;   // outer walk / output index
  logic [CW-1:0] cmp_j;
  logic [IW-1:0] start;
  logic [CW-1:0] top;
  logic [CW-1:0] walk_size;
  logic [MAX_INTERVALS-1:0] visited;
  logic [MAX_INTERVALS-1:0] comp_side;
  logic [CW-1:0] tot0, tot1;
  logic signed [EB-1:0] node_lo, node_hi;

  // Endpoint conversion to EB bits.
  logic signed [EB-1:0] ea, eb, lo_in, hi_in;
  always_comb begin
    ea = EB'($signed(in_ch.data.end_a));
    eb = EB'($signed(in_ch.data.end_b));
    lo_in = (ea > eb) ? eb : ea;
    hi_in = (ea > eb) ? ea : eb;
  end

  // Memories: interval lows/highs, labels, walk stack.
  logic          lh_we;
  logic [IW-1:0] lh_wa, lh_ra;
  logic signed [EB-1:0] lo_rd, hi_rd;
  logic          lb_we;
  logic [IW-1:0] lb_wa, lb_ra, lb_wd, lb_rd;
  logic          sk_we;
  logic [IW-1:0] sk_wa, sk_ra, sk_wd, sk_rd;

  iog_mem #(.DEPTH(MAX_INTERVALS), .WIDTH(EB)) u_lo (
    .clk, .we(lh_we), .waddr(lh_wa), .wdata(lo_in), .raddr(lh_ra), .rdata(lo_rd));
  iog_mem #(.DEPTH(MAX_INTERVALS), .WIDTH(EB)) u_hi (
    .clk, .we(lh_we), .waddr(lh_wa), .wdata(hi_in), .raddr(lh_ra), .rdata(hi_rd));
  iog_mem #(.DEPTH(MAX_INTERVALS), .WIDTH(IW)) u_lab (
    .clk, .we(lb_we), .waddr(lb_wa), .wdata(lb_wd), .raddr(lb_ra), .rdata(lb_rd));
  iog_mem #(.DEPTH(MAX_INTERVALS), .WIDTH(IW)) u_stk (
    .clk, .we(sk_we), .waddr(sk_wa), .wdata(sk_wd), .raddr(sk_ra), .rdata(sk_rd));

  logic in_fire, out_fire, hit;
  assign in_ch.ready = (state == ST_LOAD);
  assign in_fire = in_ch.valid && in_ch.ready;
  assign out_fire = out_ch.valid && out_ch.ready;
  assign hit = !visited[cmp_j[IW-1:0]] && (node_lo <= hi_rd) && (lo_rd <= node_hi);

  // Memory port control.
  always_comb begin
    lh_we = in_fire && (count < CW'(MAX_INTERVALS));
    lh_wa = count[IW-1:0];
    lh_ra = cmp_j[IW-1:0];
    if (state == ST_STKRD) lh_ra = sk_rd;
    lb_we = 1'b0;
    lb_wa = cmp_j[IW-1:0];
    lb_wd = start;
    lb_ra = scan_i[IW-1:0];
    sk_we = 1'b0;
    sk_wa = top[IW-1:0];
    sk_wd = cmp_j[IW-1:0];
    sk_ra = top[IW-1:0] - IW'(1);
    unique case (state)
      ST_SCAN: begin
        lb_we = (scan_i < count) && !visited[scan_i[IW-1:0]];
        lb_wa = scan_i[IW-1:0];
        lb_wd = scan_i[IW-1:0];
        sk_we = lb_we;
        sk_wa = '0;
        sk_wd = scan_i[IW-1:0];
      end
      ST_CMP: begin
        lb_we = hit && (top < CW'(MAX_INTERVALS));
        sk_we = lb_we;
      end
      default: ;
    endcase
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
      count <= '0;
      ovf <= 1'b0;
      visited <= '0;
      comp_side <= '0;
      tot0 <= '0;
      tot1 <= '0;
      out_ch.valid <= 1'b0;
      scan_i <= '0;
      top <= '0;
      walk_size <= '0;
    end else begin
      unique case (state)
        ST_LOAD: if (in_fire) begin
          if (count < CW'(MAX_INTERVALS)) count <= count + CW'(1);
          else ovf <= 1'b1;
          if (in_ch.data.last_interval) begin
            scan_i <= '0;
            state <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (scan_i >= count) begin
            scan_i <= '0;
            state <= ST_OUTRD;
          end else if (!visited[scan_i[IW-1:0]]) begin
            visited[scan_i[IW-1:0]] <= 1'b1;
            walk_size <= CW'(1);
            start <= scan_i[IW-1:0];
            top <= CW'(1);
            state <= ST_POP;
          end else begin
            scan_i <= scan_i + CW'(1);
          end
        end
        ST_POP: begin
          if (top == '0) begin
            // Component complete: give it to the side that is not larger.
            if (tot0 > tot1) begin
              tot1 <= tot1 + walk_size;
              comp_side[start] <= 1'b1;
            end else begin
              tot0 <= tot0 + walk_size;
              comp_side[start] <= 1'b0;
            end
            scan_i <= scan_i + CW'(1);
            state <= ST_SCAN;
          end else begin
            // Stack read of the top entry is issued this cycle.
            top <= top - CW'(1);
            state <= ST_STKRD;
          end
        end
        ST_STKRD: begin
          // Stack data is valid; the node's endpoints are read next.
          state <= ST_NODERD;
        end
        ST_NODERD: begin
          node_lo <= lo_rd;
          node_hi <= hi_rd;
          cmp_j <= '0;
          state <= ST_CMPRD;
        end
        ST_CMPRD: begin
          // Read of interval cmp_j is issued here, compared next cycle.
          if (cmp_j >= count) state <= ST_POP;
          else state <= ST_CMP;
        end
        ST_CMP: begin
          if (lb_we) begin
            visited[cmp_j[IW-1:0]] <= 1'b1;
            walk_size <= walk_size + CW'(1);
            top <= top + CW'(1);
          end
          cmp_j <= cmp_j + CW'(1);
          state <= ST_CMPRD;
        end
        ST_OUTRD: begin
          if (scan_i >= count) begin
            count <= '0;
            ovf <= 1'b0;
            visited <= '0;
            comp_side <= '0;
            tot0 <= '0;
            tot1 <= '0;
            state <= ST_LOAD;
          end else begin
            state <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (!out_ch.valid) begin
            out_ch.valid <= 1'b1;
            out_ch.data.interval_index <= 6'(scan_i);
            out_ch.data.component_label <= 6'(lb_rd);
            out_ch.data.side <= comp_side[lb_rd];
            out_ch.data.last_result <= (scan_i + CW'(1) == count);
            out_ch.data.overflow <= ovf;
          end else if (out_fire) begin
            out_ch.valid <= 1'b0;
            scan_i <= scan_i + CW'(1);
            state <= ST_OUTRD;
          end
        end
        default: state <= ST_LOAD;
      endcase
    end
  end

  // Checks.
  a_no_in_busy: assert property (@(posedge clk) disable iff (rst)
    state != ST_LOAD |-> !in_ch.ready) else $error("input taken while busy");
  a_top_range: assert property (@(posedge clk) disable iff (rst)
    top <= CW'(MAX_INTERVALS)) else $error("walk stack overrun");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_INTERVALS)) else $error("count overrun");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && !out_ch.ready |=> out_ch.valid) else $error("result dropped");
  a_state_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot(state)) else $error("state not one-hot");
endmodule
